// ===== rtl/core/tth_pkg.sv =====
// Package for the thermal throttle core: field widths, throttle level codes,
// configuration register indexes and the structs shared between modules.
// No dependencies.
package tth_pkg;

	localparam int TEMP_W = 8;
	localparam int FREQ_W = 22;
	localparam int LVL_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = FREQ_W;

	typedef logic [TEMP_W-1:0] temp_t;
	typedef logic [FREQ_W-1:0] freq_t;
	typedef logic [LVL_W-1:0]  lvl_t;

	localparam lvl_t LVL_NONE = 2'd0;
	localparam lvl_t LVL_LOW  = 2'd1;
	localparam lvl_t LVL_MID  = 2'd2;
	localparam lvl_t LVL_MAX  = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CRIT_TEMP     = 3'd0,
		REG_LOW_TRIP      = 3'd1,
		REG_LOW_CLEAR     = 3'd2,
		REG_MID_TRIP      = 3'd3,
		REG_MID_CLEAR     = 3'd4,
		REG_MAX_TRIP      = 3'd5,
		REG_MAX_CLEAR     = 3'd6,
		REG_FALLBACK_FREQ = 3'd7
	} cfg_reg_t;

	localparam temp_t RST_CRIT_TEMP     = 8'd255;
	localparam temp_t RST_LOW_TRIP      = 8'd70;
	localparam temp_t RST_LOW_CLEAR     = 8'd64;
	localparam temp_t RST_MID_TRIP      = 8'd75;
	localparam temp_t RST_MID_CLEAR     = 8'd68;
	localparam temp_t RST_MAX_TRIP      = 8'd85;
	localparam temp_t RST_MAX_CLEAR     = 8'd73;
	localparam freq_t RST_FALLBACK_FREQ = 22'd1512000;

	// Threshold set handed to the decision logic.
	typedef struct packed {
		temp_t crit_temp;
		temp_t low_trip;
		temp_t low_clear;
		temp_t mid_trip;
		temp_t mid_clear;
		temp_t max_trip;
		temp_t max_clear;
		freq_t fallback_freq;
	} thresh_t;

	// One result item.
	typedef struct packed {
		logic  update;
		lvl_t  level;
		logic  restore;
		freq_t restore_freq;
		logic  shutdown;
	} result_t;

endpackage

// ===== rtl/core/tth_if.sv =====
// Channel interfaces for the thermal throttle core: sample input and result
// output, each a valid/ready handshake with its payload. Depends on tth_pkg.
interface tth_in_if;
	logic             valid;
	logic             ready;
	tth_pkg::temp_t   temp;
	tth_pkg::freq_t   policy_max_freq;
	logic             sample_ok;

	modport source (output valid, temp, policy_max_freq, sample_ok, input ready);
	modport sink (input valid, temp, policy_max_freq, sample_ok, output ready);
endinterface

interface tth_out_if;
	logic             valid;
	logic             ready;
	logic             update;
	tth_pkg::lvl_t    level;
	logic             restore;
	tth_pkg::freq_t   restore_freq;
	logic             shutdown;

	modport source (output valid, update, level, restore, restore_freq, shutdown,
		input ready);
	modport sink (input valid, update, level, restore, restore_freq, shutdown,
		output ready);
endinterface

// ===== rtl/core/tth_decide.sv =====
// Combinational throttle decision for one sample: shutdown check, ceiling
// save and the prioritized trip/clear rules. Depends on tth_pkg.
module tth_decide (
	input  tth_pkg::thresh_t th,
	input  tth_pkg::temp_t   temp,
	input  logic             sample_ok,
	input  tth_pkg::lvl_t    cur_level,
	input  tth_pkg::freq_t   saved_ceiling,
	output tth_pkg::result_t res,
	output tth_pkg::lvl_t    next_level,
	output logic             save_ceiling
);
	import tth_pkg::*;

	logic shut;
	lvl_t base_lvl;
	lvl_t lvl;
	logic upd;
	logic rst;

	assign shut     = (temp >= th.crit_temp);
	// Shutdown forces the top level before any rule is looked at.
	assign base_lvl = shut ? LVL_MAX : cur_level;

	always_comb begin
		upd = 1'b0;
		rst = 1'b0;
		lvl = base_lvl;
		if (temp >= th.low_trip && temp < th.mid_trip && base_lvl < LVL_LOW) begin
			upd = 1'b1;
			lvl = LVL_LOW;
		end else if (temp < th.low_clear && base_lvl > LVL_NONE) begin
			upd = 1'b1;
			rst = 1'b1;
			lvl = LVL_NONE;
		end else if (temp >= th.mid_trip && temp < th.max_trip && base_lvl < LVL_MID) begin
			upd = 1'b1;
			lvl = LVL_MID;
		end else if (temp < th.mid_clear && base_lvl > LVL_LOW) begin
			upd = 1'b1;
			lvl = LVL_LOW;
		end else if (temp >= th.max_trip) begin
			upd = 1'b1;
			lvl = LVL_MAX;
		end else if (temp < th.max_clear && base_lvl > LVL_MID) begin
			upd = 1'b1;
			lvl = LVL_MID;
		end
	end

	// A restore only happens from a throttled level, where no new ceiling is
	// saved, so the stored ceiling (or the fallback frequency when none is stored) is handed back.
	always_comb begin
		res          = '0;
		res.level    = cur_level;
		next_level   = cur_level;
		save_ceiling = 1'b0;
		if (sample_ok) begin
			res.update   = upd;
			res.level    = lvl;
			res.restore  = rst;
			res.shutdown = shut;
			if (rst) begin
				res.restore_freq = (saved_ceiling != '0) ? saved_ceiling : th.fallback_freq;
			end
			next_level   = lvl;
			save_ceiling = (base_lvl == LVL_NONE);
		end
	end

endmodule

// ===== rtl/core/thermal_throttle_hysteresis_core.sv =====
// Thermal throttle core with hysteresis. A sample is taken into stage 1
// and its result is registered in stage 2, which drives the output channel.
// Throughput: one sample per cycle while the output is not stalled; the level
// feedback is committed as a result moves into stage 2. Reset (arst_n low,
// asynchronous) loads the default thresholds, clears the throttle level and
// the saved ceiling, and empties both pipeline stages. Depends on tth_pkg, tth_if and tth_decide.
module thermal_throttle_hysteresis_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [tth_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tth_pkg::CFG_DATA_W-1:0] cfg_data,
	tth_in_if.sink                   in_ch,
	tth_out_if.source                out_ch
);
	import tth_pkg::*;

	// Configuration registers.
	thresh_t th_q;

	// Throttle state.
	lvl_t  level_q;
	freq_t saved_q;

	// Stage 1 holds the accepted sample.
	logic  v_s1;
	temp_t temp_s1;
	freq_t freq_s1;
	logic  ok_s1;

	// Stage 2 is the result register that drives the output channel.
	logic    v_s2;
	result_t res_s2;

	// Decision outputs.
	result_t res_d;
	lvl_t    next_level;
	logic    save_ceiling;

	logic adv_s2;
	logic adv_s1;
	logic fire_s1;

	// Each stage moves whenever it is empty or the one after it is moving, so
	// a waiting result stops a new sample from being taken only once stage 1 is full.
	assign adv_s2  = !v_s2 || out_ch.ready;
	assign adv_s1  = !v_s1 || adv_s2;
	assign fire_s1 = v_s1 && adv_s2;
	assign in_ch.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th_q.crit_temp     <= RST_CRIT_TEMP;
			th_q.low_trip      <= RST_LOW_TRIP;
			th_q.low_clear     <= RST_LOW_CLEAR;
			th_q.mid_trip      <= RST_MID_TRIP;
			th_q.mid_clear     <= RST_MID_CLEAR;
			th_q.max_trip      <= RST_MAX_TRIP;
			th_q.max_clear     <= RST_MAX_CLEAR;
			th_q.fallback_freq <= RST_FALLBACK_FREQ;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CRIT_TEMP:     th_q.crit_temp     <= cfg_data[TEMP_W-1:0];
				REG_LOW_TRIP:      th_q.low_trip      <= cfg_data[TEMP_W-1:0];
				REG_LOW_CLEAR:     th_q.low_clear     <= cfg_data[TEMP_W-1:0];
				REG_MID_TRIP:      th_q.mid_trip      <= cfg_data[TEMP_W-1:0];
				REG_MID_CLEAR:     th_q.mid_clear     <= cfg_data[TEMP_W-1:0];
				REG_MAX_TRIP:      th_q.max_trip      <= cfg_data[TEMP_W-1:0];
				REG_MAX_CLEAR:     th_q.max_clear     <= cfg_data[TEMP_W-1:0];
				REG_FALLBACK_FREQ: th_q.fallback_freq <= cfg_data[FREQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The decision reads the sample from stage 1 and the current state.
	tth_decide u_decide (
		.th            (th_q),
		.temp          (temp_s1),
		.sample_ok     (ok_s1),
		.cur_level     (level_q),
		.saved_ceiling (saved_q),
		.res           (res_d),
		.next_level    (next_level),
		.save_ceiling  (save_ceiling)
	);

	// State is committed in the same cycle the sample moves into stage 2, so
	// the next sample in stage 1 already sees the updated level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LVL_NONE;
			saved_q <= '0;
		end else if (fire_s1) begin
			level_q <= next_level;
			if (save_ceiling) begin
				saved_q <= freq_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_ch.valid) begin
			temp_s1 <= in_ch.temp;
			freq_s1 <= in_ch.policy_max_freq;
			ok_s1   <= in_ch.sample_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_ch.valid        = v_s2;
	assign out_ch.update       = res_s2.update;
	assign out_ch.level        = res_s2.level;
	assign out_ch.restore      = res_s2.restore;
	assign out_ch.restore_freq = res_s2.restore_freq;
	assign out_ch.shutdown     = res_s2.shutdown;

endmodule

// ===== rtl/core/tth_checker.sv =====
// Port-level checks for the thermal throttle core, attached by the bind
// statement at the end of this file. Depends on tth_pkg and the core.
module tth_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input logic           update,
	input tth_pkg::lvl_t  level,
	input logic           restore,
	input tth_pkg::freq_t restore_freq,
	input logic           shutdown
);
	import tth_pkg::*;

	// A restore is always an update that lands at the unthrottled level.
	a_restore_update: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && restore |-> update && level == LVL_NONE)
		else $error("restore without update to level 0");

	// Without a restore the restore frequency reads as zero.
	a_freq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !restore |-> restore_freq == '0)
		else $error("restore_freq nonzero without restore");

	// A stalled result stays presented and unchanged.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(update) && $stable(level)
			&& $stable(restore) && $stable(restore_freq) && $stable(shutdown))
		else $error("stalled result changed");

	// Nothing is offered while reset is held.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind thermal_throttle_hysteresis_core tth_checker u_tth_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.update       (out_ch.update),
	.level        (out_ch.level),
	.restore      (out_ch.restore),
	.restore_freq (out_ch.restore_freq),
	.shutdown     (out_ch.shutdown)
);
